### rtl/minimum_image_distance_2d_defines.svh
// Assertion macros for the minimum image distance block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef MINIMUM_IMAGE_DISTANCE_2D_DEFINES_SVH
`define MINIMUM_IMAGE_DISTANCE_2D_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define MID_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed");

// Condition holds after the delay given by dly, counted from the trigger.
`define MID_ASSERT_AFTER(lbl, trig, dly, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> ##dly (cond)) \
    else $error("assertion failed");

`endif

### rtl/mid_pkg.sv
// Shared types and constants for the minimum image distance block.
// No dependencies.
package mid_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int NUM_W     = COORD_W + 2;
  localparam int DEN_W     = COORD_W + 1;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int RAD_W     = 2 * COORD_W;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int ZSQ_W     = 2 * COORD_W - 1;
  localparam int CFG_IDX_W = 3;

  // accept edge to strobe edge, in clock edges
  localparam int PIPE_LAT  = NUM_W + ROOT_W + 8;

  localparam logic [COORD_W-1:0] BOX_DIAG_RST = COORD_W'(10) << FRAC_BITS;
  localparam logic [COORD_W-1:0] KCLAMP       = COORD_W'(1) << 30;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_AX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_AY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_AZ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_BX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_BY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_BZ = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_first_x;
    logic signed [COORD_W-1:0] pos_first_y;
    logic signed [COORD_W-1:0] pos_first_z;
    logic signed [COORD_W-1:0] pos_second_x;
    logic signed [COORD_W-1:0] pos_second_y;
    logic signed [COORD_W-1:0] pos_second_z;
  } in_t;

  typedef struct packed {
    logic        [COORD_W-1:0] distance;
    logic signed [COORD_W-1:0] delta_z;
    logic        [ZSQ_W-1:0]   delta_z_sq;
    logic                      divide_fault;
  } out_t;

endpackage

### rtl/minimum_image_distance_2d.sv
// Pipeline: each accepted start strobes a result on out_valid after passing
// 34 divider stages, 6 arithmetic stages, 32 square root stages and I/O regs.
// Throughput: one item per cycle; busy stays low, since the pipeline never stalls.
// Reset (synchronous, rst_n low) clears all valid bits and loads the box
// vectors a = (10, 0, 0) and b = (0, 10, 0) in Q16.16.
module minimum_image_distance_2d import mid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  output logic                 out_valid,
  output out_t                 out_data
);

`include "minimum_image_distance_2d_defines.svh"

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic                     negx;
    logic                     negy;
    logic                     fault;
  } div_side_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] wz;
    logic        [ZSQ_W-1:0]   zsq;
    logic                      sat;
    logic                      fault;
  } sq_side_t;

  logic signed [COORD_W-1:0] box_ax_r, box_ay_r, box_az_r;
  logic signed [COORD_W-1:0] box_bx_r, box_by_r, box_bz_r;

  logic accept;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_ax_r <= BOX_DIAG_RST;
      box_ay_r <= '0;
      box_az_r <= '0;
      box_bx_r <= '0;
      box_by_r <= BOX_DIAG_RST;
      box_bz_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOX_AX: box_ax_r <= cfg_data;
        REG_BOX_AY: box_ay_r <= cfg_data;
        REG_BOX_AZ: box_az_r <= cfg_data;
        REG_BOX_BX: box_bx_r <= cfg_data;
        REG_BOX_BY: box_by_r <= cfg_data;
        REG_BOX_BZ: box_bz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: differences, divider operands
  logic signed [DIFF_W-1:0] dx_c, dy_c, dz_c;
  logic signed [NUM_W:0]    nx_c, ny_c;
  logic signed [DEN_W-1:0]  d2x_c, d2y_c;
  logic        [NUM_W-1:0]  num_x_r, num_y_r;
  logic        [DEN_W-1:0]  den_x_r, den_y_r;
  div_side_t                s1_r;
  logic                     v1_r;

  always_comb begin
    dx_c  = {in_data.pos_first_x[COORD_W-1], in_data.pos_first_x}
          - {in_data.pos_second_x[COORD_W-1], in_data.pos_second_x};
    dy_c  = {in_data.pos_first_y[COORD_W-1], in_data.pos_first_y}
          - {in_data.pos_second_y[COORD_W-1], in_data.pos_second_y};
    dz_c  = {in_data.pos_first_z[COORD_W-1], in_data.pos_first_z}
          - {in_data.pos_second_z[COORD_W-1], in_data.pos_second_z};
    nx_c  = {dx_c[DIFF_W-1], dx_c, 1'b0} - {{3{box_ax_r[COORD_W-1]}}, box_ax_r};
    ny_c  = {dy_c[DIFF_W-1], dy_c, 1'b0} - {{3{box_by_r[COORD_W-1]}}, box_by_r};
    d2x_c = {box_ax_r, 1'b0};
    d2y_c = {box_by_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    num_x_r    <= nx_c[NUM_W] ? NUM_W'(-nx_c) : nx_c[NUM_W-1:0];
    num_y_r    <= ny_c[NUM_W] ? NUM_W'(-ny_c) : ny_c[NUM_W-1:0];
    den_x_r    <= d2x_c[DEN_W-1] ? DEN_W'(-d2x_c) : DEN_W'(d2x_c);
    den_y_r    <= d2y_c[DEN_W-1] ? DEN_W'(-d2y_c) : DEN_W'(d2y_c);
    s1_r.dx    <= dx_c;
    s1_r.dy    <= dy_c;
    s1_r.dz    <= dz_c;
    s1_r.negx  <= nx_c[NUM_W] ^ box_ax_r[COORD_W-1];
    s1_r.negy  <= ny_c[NUM_W] ^ box_by_r[COORD_W-1];
    s1_r.fault <= (box_ax_r == '0) || (box_by_r == '0);
  end

  // Divider lanes for the two image counts
  logic [NUM_W-1:0] qx, qy;
  logic             rnzx, rnzy;

  mid_div_pipe #(.N_W(NUM_W), .D_W(DEN_W)) u_div_x (
    .clk(clk), .num_i(num_x_r), .den_i(den_x_r), .quo_o(qx), .rem_nz_o(rnzx)
  );
  mid_div_pipe #(.N_W(NUM_W), .D_W(DEN_W)) u_div_y (
    .clk(clk), .num_i(num_y_r), .den_i(den_y_r), .quo_o(qy), .rem_nz_o(rnzy)
  );

  div_side_t        dside_r [NUM_W];
  logic [NUM_W-1:0] vdiv_r;

  always_ff @(posedge clk) begin
    dside_r[0] <= s1_r;
    for (int i = 1; i < NUM_W; i++) begin
      dside_r[i] <= dside_r[i-1];
    end
  end

  // Stage B: rounding fix-up and clamp of the image counts
  function automatic logic signed [COORD_W-1:0] clamp_count(
    input logic [NUM_W-1:0] q, input logic nz, input logic neg);
    logic [NUM_W:0] qp;
    begin
      qp = {1'b0, q} + (NUM_W+1)'(nz);
      if (neg) begin
        clamp_count = (q > NUM_W'(KCLAMP)) ? -KCLAMP : COORD_W'(-q);
      end else begin
        clamp_count = (qp > (NUM_W+1)'(KCLAMP)) ? KCLAMP : qp[COORD_W-1:0];
      end
    end
  endfunction

  div_side_t                 b_r;
  logic signed [COORD_W-1:0] kx_r, ky_r;

  always_ff @(posedge clk) begin
    b_r  <= dside_r[NUM_W-1];
    kx_r <= clamp_count(qx, rnzx, dside_r[NUM_W-1].negx);
    ky_r <= clamp_count(qy, rnzy, dside_r[NUM_W-1].negy);
  end

  // Stage C: image offsets
  logic signed [PROD_W-1:0] pxa_r, pxb_r, pya_r, pyb_r, pza_r, pzb_r;
  div_side_t                c_r;

  always_ff @(posedge clk) begin
    c_r   <= b_r;
    pxa_r <= kx_r * box_ax_r;
    pxb_r <= ky_r * box_bx_r;
    pya_r <= kx_r * box_ay_r;
    pyb_r <= ky_r * box_by_r;
    pza_r <= kx_r * box_az_r;
    pzb_r <= ky_r * box_bz_r;
  end

  // Stage D: wrapped vector
  logic signed [PROD_W-1:0] wx_r, wy_r, wz_r;
  logic                     d_fault_r;

  always_ff @(posedge clk) begin
    d_fault_r <= c_r.fault;
    wx_r <= PROD_W'(c_r.dx) - pxa_r - pxb_r;
    wy_r <= PROD_W'(c_r.dy) - pya_r - pyb_r;
    wz_r <= PROD_W'(c_r.dz) - pza_r - pzb_r;
  end

  // Stage E: magnitudes and z saturation
  logic [PROD_W-1:0]         mx_c, my_c, mz_c;
  logic                      zovf_c;
  logic signed [COORD_W-1:0] wzs_c;
  logic [COORD_W-1:0]        mx_r, my_r, mz_r, zabs_r;
  logic signed [COORD_W-1:0] e_wz_r;
  logic                      e_big_r, e_fault_r;

  always_comb begin
    mx_c   = wx_r[PROD_W-1] ? PROD_W'(-wx_r) : PROD_W'(wx_r);
    my_c   = wy_r[PROD_W-1] ? PROD_W'(-wy_r) : PROD_W'(wy_r);
    mz_c   = wz_r[PROD_W-1] ? PROD_W'(-wz_r) : PROD_W'(wz_r);
    zovf_c = (wz_r[PROD_W-1:COORD_W-1] != '0) && (wz_r[PROD_W-1:COORD_W-1] != '1);
    if (zovf_c) begin
      wzs_c = wz_r[PROD_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      wzs_c = wz_r[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    mx_r      <= mx_c[COORD_W-1:0];
    my_r      <= my_c[COORD_W-1:0];
    mz_r      <= mz_c[COORD_W-1:0];
    e_big_r   <= (|mx_c[PROD_W-1:COORD_W]) | (|my_c[PROD_W-1:COORD_W])
               | (|mz_c[PROD_W-1:COORD_W]);
    e_wz_r    <= wzs_c;
    zabs_r    <= wzs_c[COORD_W-1] ? COORD_W'(-wzs_c) : COORD_W'(wzs_c);
    e_fault_r <= d_fault_r;
  end

  // Stage F: squares
  logic [PROD_W-1:0]         sqx_r, sqy_r, sqz_r, zsq_r;
  logic signed [COORD_W-1:0] f_wz_r;
  logic                      f_big_r, f_fault_r;

  always_ff @(posedge clk) begin
    sqx_r     <= PROD_W'(mx_r) * PROD_W'(mx_r);
    sqy_r     <= PROD_W'(my_r) * PROD_W'(my_r);
    sqz_r     <= PROD_W'(mz_r) * PROD_W'(mz_r);
    zsq_r     <= PROD_W'(zabs_r) * PROD_W'(zabs_r);
    f_wz_r    <= e_wz_r;
    f_big_r   <= e_big_r;
    f_fault_r <= e_fault_r;
  end

  // Stage G: sum of squares
  logic [PROD_W+1:0] sum_c;
  logic [RAD_W-1:0]  rad_r;
  sq_side_t          g_r;

  assign sum_c = (PROD_W+2)'(sqx_r) + (PROD_W+2)'(sqy_r) + (PROD_W+2)'(sqz_r);

  always_ff @(posedge clk) begin
    rad_r   <= sum_c[RAD_W-1:0];
    g_r.wz  <= f_wz_r;
    g_r.zsq <= zsq_r[ZSQ_W-1:0];
    g_r.sat <= f_big_r | (|sum_c[PROD_W+1:PROD_W]);
    g_r.fault <= f_fault_r;
  end

  logic [ROOT_W-1:0] root;

  mid_sqrt_pipe #(.R_W(RAD_W)) u_sqrt (
    .clk(clk), .rad_i(rad_r), .root_o(root)
  );

  sq_side_t          sside_r [ROOT_W];
  logic [ROOT_W-1:0] vsq_r;

  always_ff @(posedge clk) begin
    sside_r[0] <= g_r;
    for (int i = 1; i < ROOT_W; i++) begin
      sside_r[i] <= sside_r[i-1];
    end
  end

  // Valid chain travels with the data
  logic [5:0] vmid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      vdiv_r <= '0;
      vmid_r <= '0;
      vsq_r  <= '0;
    end else begin
      v1_r   <= accept;
      vdiv_r <= {vdiv_r[NUM_W-2:0], v1_r};
      vmid_r <= {vmid_r[4:0], vdiv_r[NUM_W-1]};
      vsq_r  <= {vsq_r[ROOT_W-2:0], vmid_r[5]};
    end
  end

  // Output register
  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vsq_r[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (sside_r[ROOT_W-1].fault) begin
      out_data_r <= '{distance: '0, delta_z: '0, delta_z_sq: '0, divide_fault: 1'b1};
    end else begin
      out_data_r.distance     <= sside_r[ROOT_W-1].sat ? '1 : root;
      out_data_r.delta_z      <= sside_r[ROOT_W-1].wz;
      out_data_r.delta_z_sq   <= sside_r[ROOT_W-1].zsq;
      out_data_r.divide_fault <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic [COORD_W-1:0] out_zabs;
  assign out_zabs = out_data.delta_z[COORD_W-1] ? COORD_W'(-out_data.delta_z)
                                                : COORD_W'(out_data.delta_z);

  `MID_ASSERT_AFTER(a_accept_gives_result, accept, 74, out_valid)
  `MID_ASSERT_AFTER(a_no_result_unasked, !accept, 74, !out_valid)
  `MID_ASSERT_NOW(a_fault_zeroes, out_valid && out_data.divide_fault,
                  out_data.distance == '0 && out_data.delta_z == '0)
  `MID_ASSERT_NOW(a_dist_covers_z, out_valid && !out_data.divide_fault,
                  out_data.distance >= out_zabs)

endmodule

### rtl/mid_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on mid_pkg for default widths.
module mid_div_pipe import mid_pkg::*; #(
  parameter int N_W = NUM_W,
  parameter int D_W = DEN_W
) (
  input  logic           clk,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic [N_W-1:0] quo_o,
  output logic           rem_nz_o
);

  localparam int REM_W = D_W + 1;

  logic [REM_W-1:0] rem_r [N_W];
  logic [N_W-1:0]   num_r [N_W];
  logic [N_W-1:0]   quo_r [N_W];
  logic [D_W-1:0]   den_r [N_W];

  for (genvar s = 0; s < N_W; s++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [N_W-1:0]   num_in;
    logic [N_W-1:0]   quo_in;
    logic [D_W-1:0]   den_in;
    logic [REM_W-1:0] trial;
    logic [REM_W:0]   diff;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
    end

    always_comb begin
      trial = {rem_in[REM_W-2:0], num_in[N_W-1]};
      diff  = {1'b0, trial} - {2'b00, den_in};
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= diff[REM_W] ? trial : diff[REM_W-1:0];
      num_r[s] <= num_in << 1;
      quo_r[s] <= {quo_in[N_W-2:0], ~diff[REM_W]};
      den_r[s] <= den_in;
    end
  end

  assign quo_o    = quo_r[N_W-1];
  assign rem_nz_o = |rem_r[N_W-1];

endmodule

### rtl/mid_sqrt_pipe.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on mid_pkg for default widths.
module mid_sqrt_pipe import mid_pkg::*; #(
  parameter int R_W = RAD_W
) (
  input  logic             clk,
  input  logic [R_W-1:0]   rad_i,
  output logic [R_W/2-1:0] root_o
);

  localparam int RT_W  = R_W / 2;
  localparam int REM_W = RT_W + 3;

  logic [REM_W-1:0] rem_r  [RT_W];
  logic [R_W-1:0]   rad_r  [RT_W];
  logic [RT_W-1:0]  root_r [RT_W];

  for (genvar s = 0; s < RT_W; s++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [R_W-1:0]   rad_in;
    logic [RT_W-1:0]  root_in;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic [REM_W:0]   diff;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign rad_in  = rad_r[s-1];
      assign root_in = root_r[s-1];
    end

    always_comb begin
      cur   = {rem_in[REM_W-3:0], rad_in[R_W-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      diff  = {1'b0, cur} - {1'b0, trial};
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= diff[REM_W] ? cur : diff[REM_W-1:0];
      rad_r[s]  <= rad_in << 2;
      root_r[s] <= {root_in[RT_W-2:0], ~diff[REM_W]};
    end
  end

  assign root_o = root_r[RT_W-1];

endmodule
